[design/wms_pkg.sv]
// Package for the waypoint mission sequencer: mode codes, config indexes, widths.
// No dependencies.
package wms_pkg;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_TAKEOFF = 3'd1,
        M_ENROUTE = 3'd2,
        M_HOVER   = 3'd3,
        M_LANDING = 3'd4
    } t_mode;

    localparam logic [1:0] CFG_CLIMB   = 2'd0;
    localparam logic [1:0] CFG_TAKEOFF = 2'd1;
    localparam logic [1:0] CFG_RADIUS  = 2'd2;
    localparam logic [1:0] CFG_CRUISE  = 2'd3;

    localparam int POS_W  = 24;
    localparam int HOLD_W = 20;
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    // Saturate a wide signed value to 24 bits.
    function automatic logic signed [POS_W-1:0] sat24(input logic signed [27:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 28'sd8388607) begin
            r = POS_MAX;
        end else if (v < -28'sd8388608) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Sequencer phases.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DIST,
        S_SUM,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_APPLY,
        S_OUT
    } t_seq;

endpackage

[design/wms_ram.sv]
// Generic single-port-write RAM with registered read.
// No dependencies.
module wms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/wms_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing.
module wms_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_value,
    output logic        o_done,
    output logic [24:0] o_root
);
    logic [49:0] r_rem, n_rem;
    logic [49:0] r_root, n_root;
    logic [49:0] r_bit, n_bit;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [49:0] trial;

    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = r_root + r_bit;
        if (i_start) begin
            n_rem  = i_value;
            n_root = '0;
            n_bit  = 50'd1 << 48;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // partial root is scaled by the current bit; it settles once bit reaches 1
            if (r_rem >= trial) begin
                n_rem  = r_rem - trial;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == 50'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_root[24:0];
endmodule

[design/wms_div.sv]
// Restoring divider, one quotient bit per cycle: 57-bit dividend, 37-bit divisor.
// Depends on nothing.
module wms_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [56:0] i_num,
    input  logic [36:0] i_den,
    output logic        o_done,
    output logic [56:0] o_quot
);
    logic [56:0] r_q, n_q;
    logic [37:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [37:0] shifted;

    always_comb begin
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        shifted = {r_rem[36:0], r_q[56]};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 6'd56;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, i_den}) begin
                n_rem = shifted - {1'b0, i_den};
                n_q   = {r_q[55:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[55:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[design/waypoint_mission_sequencer.sv]
// Waypoint mission sequencer top level: sequencer, tables, sqrt and divider.
// Depends on wms_pkg, wms_ram, wms_sqrt, wms_div.
// An en route move runs setup, the square root, then one divider run per axis, then a
//   finish step; a load, or a tick outside en route, skips the square root and divider.
//   One item at a time; ready only when idle, the cycle after the result is taken.
// Reset (synchronous, active low) clears mode, indexes, position and timer and sets
//   the config registers to their defaults; waypoint tables are not cleared.
module waypoint_mission_sequencer
    import wms_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_command,
    input  logic [15:0]              i_time_step,
    input  logic signed [23:0]       i_wp_x,
    input  logic signed [23:0]       i_wp_y,
    input  logic signed [23:0]       i_wp_z,
    input  logic [19:0]              i_wp_hold,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_mission_state,
    output logic signed [23:0]       o_pos_x,
    output logic signed [23:0]       o_pos_y,
    output logic signed [23:0]       o_pos_z,
    output logic [4:0]               o_waypoint_index,
    output logic                     o_load_rejected,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [22:0]              i_cfg_data
);
    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int RW = 3 * POS_W + HOLD_W;

    logic [15:0] r_climb, r_radius, r_cruise;
    logic [22:0] r_takeoff;

    t_seq  r_seq, n_seq;
    t_mode r_mode;
    logic [CW-1:0] r_tidx, r_cnt;
    logic signed [23:0] r_px, r_py, r_pz;
    logic [19:0] r_hov;
    logic        r_cmd, r_rej;
    logic [15:0] r_dt;
    logic signed [24:0] r_dx, r_dy, r_dz;
    logic [49:0] r_sum;
    logic [24:0] r_d;
    logic [31:0] r_s;
    logic [1:0]  r_ax;
    logic signed [23:0] r_nx, r_ny, r_nz;
    logic        r_ovalid;

    // table
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata;
    logic signed [23:0] tx, ty, tz;
    logic [19:0] thold;

    assign we    = i_valid && o_ready && i_command && (r_cnt < CW'(MAX_WAYPOINTS));
    assign waddr = r_cnt[AW-1:0];
    assign raddr = r_tidx[AW-1:0];
    assign wdata = {i_wp_x, i_wp_y, i_wp_z, i_wp_hold};
    assign {tx, ty, tz, thold} = rdata;

    wms_ram #(.WIDTH(RW), .DEPTH(MAX_WAYPOINTS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic        sq_start, sq_done;
    logic [24:0] sq_root;
    wms_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_value(r_sum),
        .o_done(sq_done), .o_root(sq_root)
    );

    // squared distance terms from axis magnitudes
    logic [23:0] dmag_x, dmag_y, dmag_z;
    logic [47:0] sqx, sqy, sqz;
    assign dmag_x = r_dx[24] ? 24'(-r_dx) : r_dx[23:0];
    assign dmag_y = r_dy[24] ? 24'(-r_dy) : r_dy[23:0];
    assign dmag_z = r_dz[24] ? 24'(-r_dz) : r_dz[23:0];
    assign sqx = dmag_x * dmag_x;
    assign sqy = dmag_y * dmag_y;
    assign sqz = dmag_z * dmag_z;

    logic        dv_start, dv_done;
    logic [56:0] dv_num, dv_quot;
    logic [36:0] dv_den;
    logic signed [24:0] cur_delta;
    logic [24:0] mag;
    assign cur_delta = (r_ax == 2'd0) ? r_dx : (r_ax == 2'd1) ? r_dy : r_dz;
    assign mag    = cur_delta[24] ? 25'(-cur_delta) : cur_delta;
    assign dv_num = 57'(mag) * 57'(r_s);
    assign dv_den = {r_d, 12'd0};
    wms_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(dv_num),
        .i_den(dv_den), .o_done(dv_done), .o_quot(dv_quot)
    );

    assign o_ready     = (r_seq == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    // vertical step
    logic [31:0] vprod;
    logic [19:0] vstep;
    assign vprod = 32'(r_climb) * 32'(r_dt);
    assign vstep = vprod[31:12];

    // next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            S_IDLE:      if (i_valid && o_ready) n_seq = S_RD;
            S_RD: begin
                if (!r_cmd && r_mode == M_ENROUTE && r_tidx < r_cnt) n_seq = S_DIST;
                else n_seq = S_APPLY;
            end
            S_DIST:      n_seq = S_SUM;
            S_SUM:       n_seq = S_SQRT_GO;
            S_SQRT_GO:   n_seq = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sq_done) n_seq = S_DIV_GO;
            S_DIV_GO:    n_seq = S_DIV_WAIT;
            S_DIV_WAIT:  if (dv_done && r_ax == 2'd2) n_seq = S_APPLY;
                         else if (dv_done) n_seq = S_DIV_GO;
            S_APPLY:     n_seq = S_OUT;
            S_OUT:       n_seq = S_IDLE;
            default:     n_seq = S_IDLE;
        endcase
    end

    // outputs of sequencer
    always_comb begin
        sq_start = (r_seq == S_SQRT_GO);
        dv_start = (r_seq == S_DIV_GO);
    end

    logic signed [24:0] qs;
    logic [20:0] hsum;
    logic signed [27:0] zup, zdn;
    logic signed [23:0] zl;

    always_comb begin
        qs   = dv_quot[24] ? 25'sh0FFFFFF : 25'(dv_quot);
        if (|dv_quot[56:24]) qs = 25'sh0FFFFFF;
        if (cur_delta[24]) qs = -qs;
        hsum = 21'(r_hov) + 21'(r_dt);
        zup  = 28'(r_pz) + 28'(vstep);
        zdn  = 28'(r_pz) - 28'(vstep);
        zl   = sat24(zdn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= S_IDLE;
            r_mode    <= M_IDLE;
            r_tidx    <= '0;
            r_cnt     <= '0;
            r_px      <= '0;
            r_py      <= '0;
            r_pz      <= '0;
            r_hov     <= '0;
            r_ovalid  <= 1'b0;
            r_climb   <= 16'd256;
            r_takeoff <= 23'd1280;
            r_radius  <= 16'd51;
            r_cruise  <= 16'd512;
        end else begin
            r_seq <= n_seq;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLIMB:   r_climb   <= i_cfg_data[15:0];
                    CFG_TAKEOFF: r_takeoff <= i_cfg_data;
                    CFG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                    CFG_CRUISE:  r_cruise  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_seq == S_IDLE && i_valid && o_ready) begin
                r_cmd <= i_command;
                r_dt  <= i_time_step;
                r_rej <= i_command && (r_cnt >= CW'(MAX_WAYPOINTS));
                if (we) r_cnt <= r_cnt + CW'(1);
            end
            if (r_seq == S_DIST) begin
                r_dx  <= 25'(tx) - 25'(r_px);
                r_dy  <= 25'(ty) - 25'(r_py);
                r_dz  <= 25'(tz) - 25'(r_pz);
                r_s   <= 32'(r_cruise) * 32'(r_dt);
            end
            if (r_seq == S_SUM) begin
                r_sum <= 50'(sqx) + 50'(sqy) + 50'(sqz);
            end
            if (r_seq == S_SQRT_WAIT && sq_done) begin
                r_d  <= sq_root;
                r_ax <= 2'd0;
            end
            if (r_seq == S_DIV_WAIT && dv_done) begin
                unique case (r_ax)
                    2'd0: r_nx <= sat24(28'(r_px) + 28'(qs));
                    2'd1: r_ny <= sat24(28'(r_py) + 28'(qs));
                    default: r_nz <= sat24(28'(r_pz) + 28'(qs));
                endcase
                r_ax <= r_ax + 2'd1;
            end
            if (r_seq == S_APPLY && !r_cmd) begin
                unique case (r_mode)
                    M_IDLE: r_mode <= M_TAKEOFF;
                    M_TAKEOFF: begin
                        r_pz <= sat24(zup);
                        if (sat24(zup) >= $signed({1'b0, r_takeoff})) r_mode <= M_ENROUTE;
                    end
                    M_ENROUTE: begin
                        if (r_tidx >= r_cnt) begin
                            r_mode <= M_LANDING;
                        end else if (r_d == '0 || r_d < 25'(r_radius)) begin
                            r_mode <= M_HOVER;
                            r_hov  <= '0;
                        end else begin
                            r_px <= r_nx;
                            r_py <= r_ny;
                            r_pz <= r_nz;
                        end
                    end
                    M_HOVER: begin
                        r_hov <= hsum[20] ? 20'hFFFFF : hsum[19:0];
                        if ((hsum[20] ? 20'hFFFFF : hsum[19:0]) >= thold) begin
                            r_tidx <= r_tidx + CW'(1);
                            r_mode <= M_ENROUTE;
                        end
                    end
                    default: r_pz <= (zl <= 0) ? 24'sd0 : zl;
                endcase
            end
            if (r_seq == S_OUT) r_ovalid <= 1'b1;
        end
    end

    // The divider's quotient for d below radius is irrelevant; r_d is set
    // by the sqrt before S_APPLY whenever en route reads a waypoint.
    assign o_valid          = r_ovalid;
    assign o_mission_state  = r_mode;
    assign o_pos_x          = r_px;
    assign o_pos_y          = r_py;
    assign o_pos_z          = r_pz;
    assign o_waypoint_index = 5'(r_tidx);
    assign o_load_rejected  = r_rej;
endmodule
